// ===== design/afbfc_pkg.sv =====
// ----------------------------------------------------------------------------
// afbfc_pkg: shared types and constants
// Item and result layouts, register and code names, and the per-cell stage
// record of the aligned free-block fit check.
// ----------------------------------------------------------------------------
package afbfc_pkg;

    localparam int unsigned ADDR_BITS_DEF = 32;
    localparam int unsigned SPLIT_BIT_DEF = 31;

    // Width of every address and size field
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_UNIT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_THRESHOLD = 2'd1;

    // Request kinds
    localparam logic [1:0] KIND_META = 2'd0;
    localparam logic [1:0] KIND_RAW  = 2'd1;

    // Fit status codes
    localparam logic [1:0] FIT_REJECT   = 2'd0;
    localparam logic [1:0] FIT_EXACT    = 2'd1;
    localparam logic [1:0] FIT_LEFTOVER = 2'd2;

    typedef struct packed {
        logic [1:0]        request_kind;
        logic [WORD_W-1:0] request_size;
        logic [WORD_W-1:0] block_addr;
        logic [WORD_W-1:0] block_size;
    } item_t;

    typedef struct packed {
        logic [1:0]        fit_status;
        logic [WORD_W-1:0] start_addr;
    } result_t;

    // Record carried from cell to cell along the remainder chain
    typedef struct packed {
        logic              half_ok;
        logic              aligned;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] request_size;
        logic [WORD_W-1:0] block_addr;
        logic [WORD_W-1:0] block_size;
    } stage_t;

endpackage

// ===== design/aligned_free_block_fit_check_unit.sv =====
// ----------------------------------------------------------------------------
// aligned_free_block_fit_check_unit: aligned first-fit block check
// Checks one candidate free block against one allocation request per cycle,
// with the alignment padding worked out by a chain of remainder cells.
//
//   channel   handshake            payload
//   -------   ------------------   -----------------------------------
//   item      start / busy         request_kind, request_size,
//                                  block_addr, block_size
//   result    done (strobe)        fit_status, start_addr
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is taken every cycle; busy stays low. Each result beat passes
// through the 32 remainder cells (one address bit each), each registered, and
// then through the registered fit decision stage. Results leave in item order as a
// one-cycle done strobe; the receiver cannot stall. Reset clears the pipeline
// valid bits and sets align_unit and align_threshold to 1.
// ----------------------------------------------------------------------------
module aligned_free_block_fit_check_unit #(
    parameter int unsigned ADDR_BITS = afbfc_pkg::ADDR_BITS_DEF,
    parameter int unsigned SPLIT_BIT = afbfc_pkg::SPLIT_BIT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  afbfc_pkg::item_t                    item,
    output logic                                done,
    output afbfc_pkg::result_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [afbfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [afbfc_pkg::WORD_W-1:0]        cfg_data
);

    localparam int unsigned CELLS = afbfc_pkg::WORD_W;

    logic [afbfc_pkg::WORD_W-1:0]   align_unit_reg;
    logic [afbfc_pkg::WORD_W-1:0]   align_threshold_reg;

    logic                           chain_valid [0:CELLS];
    afbfc_pkg::stage_t              chain_stage [0:CELLS];

    logic                           upper;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_unit_reg      <= afbfc_pkg::WORD_W'(1);
            align_threshold_reg <= afbfc_pkg::WORD_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                afbfc_pkg::CFG_ALIGN_UNIT:      align_unit_reg      <= cfg_data;
                afbfc_pkg::CFG_ALIGN_THRESHOLD: align_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a split bit above the address field leaves every block in the lower half
    assign upper = |(64'(item.block_addr) & (64'd1 << SPLIT_BIT));

    assign chain_valid[0]              = start && !busy;
    assign chain_stage[0].half_ok      = !(((item.request_kind == afbfc_pkg::KIND_META) && upper) ||
                                           ((item.request_kind == afbfc_pkg::KIND_RAW) && !upper));
    assign chain_stage[0].aligned      = (item.request_size >= align_threshold_reg) &&
                                         (align_unit_reg != '0);
    assign chain_stage[0].rem          = '0;
    assign chain_stage[0].request_size = item.request_size;
    assign chain_stage[0].block_addr   = item.block_addr;
    assign chain_stage[0].block_size   = item.block_size;

    // one cell per address bit, most significant first
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        afbfc_cell #(
            .BIT_IDX (CELLS - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[k]),
            .stage_in  (chain_stage[k]),
            .divisor   (align_unit_reg),
            .valid_out (chain_valid[k+1]),
            .stage_out (chain_stage[k+1])
        );
    end

    afbfc_resolve #(
        .ADDR_BITS (ADDR_BITS)
    ) u_resolve (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (chain_valid[CELLS]),
        .stage_in (chain_stage[CELLS]),
        .done     (done),
        .result   (result)
    );

endmodule

// ===== design/afbfc_cell.sv =====
// ----------------------------------------------------------------------------
// afbfc_cell: one restoring-division step
// Shifts one address bit into the partial remainder, subtracts the alignment
// unit when it fits, and registers the record for the next cell.
// ----------------------------------------------------------------------------
module afbfc_cell #(
    parameter int unsigned BIT_IDX = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            valid_in,
    input  afbfc_pkg::stage_t               stage_in,
    input  logic [afbfc_pkg::WORD_W-1:0]    divisor,
    output logic                            valid_out,
    output afbfc_pkg::stage_t               stage_out
);

    logic                           valid_reg;
    afbfc_pkg::stage_t              stage_reg;
    afbfc_pkg::stage_t              stage_next;
    logic [afbfc_pkg::WORD_W:0]     shifted;
    logic [afbfc_pkg::WORD_W:0]     diff;

    always_comb
    begin
        shifted    = {stage_in.rem, stage_in.block_addr[BIT_IDX]};
        diff       = shifted - {1'b0, divisor};
        stage_next = stage_in;
        // keep the partial remainder below the divisor
        if (shifted >= {1'b0, divisor})
        begin
            stage_next.rem = diff[afbfc_pkg::WORD_W-1:0];
        end
        else
        begin
            stage_next.rem = shifted[afbfc_pkg::WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

// ===== design/afbfc_resolve.sv =====
// ----------------------------------------------------------------------------
// afbfc_resolve: fit decision stage
// Applies the padding from the remainder chain, classifies the block as
// exact fit, leftover fit or reject, and registers the result beat.
// ----------------------------------------------------------------------------
module afbfc_resolve #(
    parameter int unsigned ADDR_BITS = afbfc_pkg::ADDR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  afbfc_pkg::stage_t   stage_in,
    output logic                done,
    output afbfc_pkg::result_t  result
);

    localparam logic [afbfc_pkg::WORD_W-1:0] START_MASK =
        (ADDR_BITS >= afbfc_pkg::WORD_W) ? {afbfc_pkg::WORD_W{1'b1}} :
        afbfc_pkg::WORD_W'((64'd1 << ADDR_BITS) - 64'd1);

    logic                               done_reg;
    afbfc_pkg::result_t                 result_reg;
    afbfc_pkg::result_t                 result_next;
    logic [afbfc_pkg::WORD_W-1:0]       pad;
    logic [afbfc_pkg::WORD_W-1:0]       room;
    logic [afbfc_pkg::WORD_W-1:0]       sum;

    always_comb
    begin
        pad  = stage_in.aligned ? stage_in.rem : '0;
        room = stage_in.block_size - pad;
        sum  = stage_in.block_addr + pad;
        result_next.fit_status = afbfc_pkg::FIT_REJECT;
        result_next.start_addr = '0;
        if (stage_in.half_ok)
        begin
            if ((pad == '0) && (stage_in.request_size == stage_in.block_size))
            begin
                result_next.fit_status = afbfc_pkg::FIT_EXACT;
                result_next.start_addr = sum & START_MASK;
            end
            else if ((stage_in.block_size > pad) && (room >= stage_in.request_size))
            begin
                result_next.fit_status = afbfc_pkg::FIT_LEFTOVER;
                result_next.start_addr = sum & START_MASK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
